// File: rtl/core/lif_pkg.sv
// Shared widths, register indexes, reset values and types for the LIF neuron unit.
package lif_pkg;

   // Integer part of the membrane potential and default parameter values.
   localparam int INT_BITS      = 10;
   localparam int TIME_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF = 8;

   // Q0.16 arithmetic for the decay factor; one point zero needs a 17th bit.
   localparam int Q16_W = 16;
   localparam logic [Q16_W:0] ONE_Q16 = {1'b1, {Q16_W{1'b0}}};

   // Word field widths.
   localparam int ELAPSED_W = 10;
   localparam int DELTA_W   = 8;
   localparam int POT_OUT_W = 18;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int THR_W      = 10;
   localparam int LEVEL_W    = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_PER_MS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_THRESHOLD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INHIBIT_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_BOOST      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_FIRE_LEVEL   = 3'd5;

   localparam logic [Q16_W-1:0]          RST_DECAY_PER_MS      = 16'd64884;
   localparam logic signed [THR_W-1:0]   RST_FIRE_THRESHOLD    = 10'sd25;
   localparam logic signed [THR_W-1:0]   RST_DOUBLE_THRESHOLD  = 10'sd50;
   localparam logic signed [THR_W-1:0]   RST_INHIBIT_THRESHOLD = -10'sd25;
   localparam logic signed [LEVEL_W-1:0] RST_BUTTON_BOOST      = 8'sd26;
   localparam logic signed [LEVEL_W-1:0] RST_POST_FIRE_LEVEL   = 8'sd0;

   // Spike decision flags carried into the result word.
   typedef struct packed {
      logic fire_once;
      logic fire_twice;
      logic cancel_queued;
   } spike_flags_type;

endpackage

// File: rtl/core/lif_req_if.sv
// Update word channel of the LIF neuron unit.
interface lif_req_if;
   import lif_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ELAPSED_W-1:0]        elapsed_ms;
   logic signed [DELTA_W-1:0]   dendrite_delta;
   logic                        button_pressed;
   logic                        spont_mode;
   logic signed [DELTA_W-1:0]   spont_delta;
   logic                        queue_pending;

   modport source (
      output valid, elapsed_ms, dendrite_delta, button_pressed, spont_mode, spont_delta,
             queue_pending,
      input  ready
   );

   modport sink (
      input  valid, elapsed_ms, dendrite_delta, button_pressed, spont_mode, spont_delta,
             queue_pending,
      output ready
   );
endinterface

// File: rtl/core/lif_rsp_if.sv
// Result word channel of the LIF neuron unit.
interface lif_rsp_if;
   import lif_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          fire_once;
   logic                          fire_twice;
   logic                          cancel_queued;
   logic signed [POT_OUT_W-1:0]   potential_out;

   modport source (
      output valid, fire_once, fire_twice, cancel_queued, potential_out,
      input  ready
   );

   modport sink (
      input  valid, fire_once, fire_twice, cancel_queued, potential_out,
      output ready
   );
endinterface

// File: rtl/core/lif_mul.sv
// Shared unsigned multiplier with a registered product.
module lif_mul #(
   parameter int A_W = 18,
   parameter int B_W = 17
) (
   input  logic                 clock,
   input  logic                 issue,
   input  logic [A_W-1:0]       mul_a,
   input  logic [B_W-1:0]       mul_b,
   output logic [A_W+B_W-1:0]   prod_ff
);
   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W + B_W)'(mul_a) * (A_W + B_W)'(mul_b);

   // The product is held until the next operation is issued.
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
      end
   end
endmodule

// File: rtl/core/lif_sat_add.sv
// Signed adder that clamps its sum to the range of its operands.
module lif_sat_add #(
   parameter int W = 18
) (
   input  logic signed [W-1:0] add_a,
   input  logic signed [W-1:0] add_b,
   output logic signed [W-1:0] sum
);
   logic signed [W:0] wide;

   assign wide = (W + 1)'(add_a) + (W + 1)'(add_b);

   always_comb begin
      if (wide[W] != wide[W-1]) begin
         // Overflow: the carry bit gives the direction.
         sum = wide[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      end else begin
         sum = wide[W-1:0];
      end
   end
endmodule

// File: rtl/core/leaky_integrate_fire_neuron_unit.sv
// Top level of the leaky integrate-and-fire neuron unit with its update sequencer.
//
// Each word on req_ch is one update of the neuron: elapsed time, dendrite,
// button and spontaneous deltas, and whether a queued pulse could be cancelled.
// The unit answers every update word with exactly one word on rsp_ch holding
// the fire and cancel flags and the new membrane potential in signed Q10.8.
// The decay factor is raised to the elapsed time by square-and-multiply on one
// shared multiplier, two multiplies per bit of the time field, followed by
// one multiply for the decay itself and three saturating adds.
// req_ch.ready is high only while the sequencer is idle, so a new update word
// is taken only after the result of the previous one has been loaded. The
// result sits in an output register, so the next update can run while rsp_ch
// is stalled; the sequencer only waits in its final step if the earlier result
// is still held. Each write on the csr_ port with a known index loads one of
// the six configuration registers at the next clock edge; the port must be
// written by the user only while the unit is idle; the unit does not enforce it.
// A synchronous reset clears the potential, loads the register defaults and
// drops rsp_ch.valid.
module leaky_integrate_fire_neuron_unit #(
   parameter int TIME_BITS = lif_pkg::TIME_BITS_DEF,
   parameter int FRAC_BITS = lif_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lif_req_if.sink                           req_ch,
   lif_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [lif_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lif_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lif_pkg::*;

   localparam int POT_W   = INT_BITS + FRAC_BITS;
   localparam int CNT_W   = $clog2(TIME_BITS);
   localparam int MUL_A_W = (POT_W > Q16_W + 1) ? POT_W : Q16_W + 1;
   localparam int MUL_B_W = Q16_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_R  = 3'd1; // result times base
   localparam logic [2:0] ST_MUL_B  = 3'd2; // base squared
   localparam logic [2:0] ST_DECAY  = 3'd3; // magnitude times factor
   localparam logic [2:0] ST_ADD_D  = 3'd4; // dendrite delta
   localparam logic [2:0] ST_ADD_B  = 3'd5; // button boost
   localparam logic [2:0] ST_ADD_S  = 3'd6; // spontaneous delta
   localparam logic [2:0] ST_DECIDE = 3'd7; // thresholds and result word

   // Configuration registers.
   logic [Q16_W-1:0]           decay_ff;
   logic signed [THR_W-1:0]    fire_thr_ff;
   logic signed [THR_W-1:0]    double_thr_ff;
   logic signed [THR_W-1:0]    inhibit_thr_ff;
   logic signed [LEVEL_W-1:0]  boost_ff;
   logic signed [LEVEL_W-1:0]  post_ff;

   // Sequencer and datapath registers.
   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]       exp_ff, exp_in;
   logic [Q16_W:0]             r_ff, r_in;
   logic [Q16_W-1:0]           base_ff, base_in;
   logic signed [POT_W-1:0]    pot_ff, pot_in;

   // Latched update word.
   logic signed [DELTA_W-1:0]  dend_ff, dend_in;
   logic signed [DELTA_W-1:0]  sdelta_ff, sdelta_in;
   logic                       press_ff, press_in;
   logic                       spont_ff, spont_in;
   logic                       queued_ff, queued_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   spike_flags_type            rsp_flags_ff, rsp_flags_in;
   logic signed [POT_W-1:0]    rsp_pot_ff, rsp_pot_in;

   // Shared units.
   logic                       mul_issue;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [PROD_W-1:0]          prod_ff;
   logic [Q16_W-1:0]           prod_q16;
   logic signed [POT_W-1:0]    sat_a, sat_b, sat_sum;

   logic [Q16_W-1:0]           base_cur;
   logic [POT_W-1:0]           mag;
   logic [POT_W-1:0]           q_mag;
   logic signed [POT_W-1:0]    decayed;
   logic signed [POT_W-1:0]    fire_lvl, double_lvl, inhibit_lvl, post_lvl;
   logic                       last_bit;
   logic                       slot_free;

   lif_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .issue   (mul_issue),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   lif_sat_add #(
      .W (POT_W)
   ) u_sat_add (
      .add_a (sat_a),
      .add_b (sat_b),
      .sum   (sat_sum)
   );

   // A Q0.16 product keeps bits 31:16; the decayed magnitude keeps the same shift.
   assign prod_q16 = prod_ff[Q16_W +: Q16_W];
   assign q_mag    = prod_ff[Q16_W +: POT_W];

   // Magnitude of the potential; the most negative value maps to its own magnitude.
   assign mag     = pot_ff[POT_W-1] ? $unsigned(-pot_ff) : $unsigned(pot_ff);
   assign decayed = pot_ff[POT_W-1] ? -$signed(q_mag) : $signed(q_mag);

   // The first bit uses the configured factor, later bits the square just computed.
   assign base_cur = (cnt_ff == '0) ? base_ff : prod_q16;
   assign last_bit = (cnt_ff == CNT_W'(TIME_BITS - 1));

   // Integer thresholds and levels scaled into the fixed-point format.
   assign fire_lvl    = $signed({fire_thr_ff, {FRAC_BITS{1'b0}}});
   assign double_lvl  = $signed({double_thr_ff, {FRAC_BITS{1'b0}}});
   assign inhibit_lvl = $signed({inhibit_thr_ff, {FRAC_BITS{1'b0}}});
   assign post_lvl    = POT_W'(post_ff) <<< FRAC_BITS;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Multiplier operand selection.
   always_comb begin
      mul_issue = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_MUL_R: begin
            mul_issue = 1'b1;
            mul_a     = MUL_A_W'(r_ff);
            mul_b     = MUL_B_W'(base_cur);
         end
         ST_MUL_B: begin
            mul_issue = 1'b1;
            mul_a     = MUL_A_W'(base_ff);
            mul_b     = MUL_B_W'(base_ff);
         end
         ST_DECAY: begin
            mul_issue = 1'b1;
            mul_a     = MUL_A_W'(mag);
            mul_b     = r_ff;
         end
         default: begin
            mul_issue = 1'b0;
         end
      endcase
   end

   // Saturating adder operand selection; adding zero leaves an in-range value alone.
   always_comb begin
      sat_a = pot_ff;
      sat_b = '0;
      case (state_ff)
         ST_ADD_D: begin
            sat_a = decayed;
            sat_b = POT_W'(dend_ff) <<< FRAC_BITS;
         end
         ST_ADD_B: begin
            sat_b = press_ff ? (POT_W'(boost_ff) <<< FRAC_BITS) : '0;
         end
         ST_ADD_S: begin
            sat_b = spont_ff ? (POT_W'(sdelta_ff) <<< FRAC_BITS) : '0;
         end
         default: begin
            sat_b = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      pot_in       = pot_ff;
      dend_in      = dend_ff;
      sdelta_in    = sdelta_ff;
      press_in     = press_ff;
      spont_in     = spont_ff;
      queued_in    = queued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_flags_in = rsp_flags_ff;
      rsp_pot_in   = rsp_pot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               exp_in    = TIME_BITS'(req_ch.elapsed_ms);
               dend_in   = req_ch.dendrite_delta;
               sdelta_in = req_ch.spont_delta;
               press_in  = req_ch.button_pressed;
               spont_in  = req_ch.spont_mode;
               queued_in = req_ch.queue_pending;
               r_in      = ONE_Q16;
               base_in   = decay_ff;
               cnt_in    = '0;
               state_in  = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            base_in  = base_cur;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            if (exp_ff[0]) begin
               r_in = {1'b0, prod_q16};
            end
            exp_in = exp_ff >> 1;
            if (last_bit) begin
               state_in = ST_DECAY;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MUL_R;
            end
         end
         ST_DECAY: begin
            state_in = ST_ADD_D;
         end
         ST_ADD_D: begin
            pot_in   = sat_sum;
            state_in = ST_ADD_B;
         end
         ST_ADD_B: begin
            pot_in   = sat_sum;
            state_in = ST_ADD_S;
         end
         ST_ADD_S: begin
            pot_in   = sat_sum;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (slot_free) begin
               rsp_flags_in = '0;
               if (pot_ff > double_lvl) begin
                  rsp_flags_in.fire_once  = 1'b1;
                  rsp_flags_in.fire_twice = 1'b1;
                  pot_in                  = post_lvl;
               end else if (pot_ff > fire_lvl) begin
                  rsp_flags_in.fire_once = 1'b1;
                  pot_in                 = post_lvl;
               end else if ((pot_ff < inhibit_lvl) && queued_ff) begin
                  rsp_flags_in.cancel_queued = 1'b1;
                  pot_in                     = '0;
               end
               rsp_pot_in   = pot_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pot_ff       <= pot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      exp_ff       <= exp_in;
      r_ff         <= r_in;
      base_ff      <= base_in;
      dend_ff      <= dend_in;
      sdelta_ff    <= sdelta_in;
      press_ff     <= press_in;
      spont_ff     <= spont_in;
      queued_ff    <= queued_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_pot_ff   <= rsp_pot_in;
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff       <= RST_DECAY_PER_MS;
         fire_thr_ff    <= RST_FIRE_THRESHOLD;
         double_thr_ff  <= RST_DOUBLE_THRESHOLD;
         inhibit_thr_ff <= RST_INHIBIT_THRESHOLD;
         boost_ff       <= RST_BUTTON_BOOST;
         post_ff        <= RST_POST_FIRE_LEVEL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECAY_PER_MS:      decay_ff       <= csr_wdata;
            CSR_FIRE_THRESHOLD:    fire_thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_DOUBLE_THRESHOLD:  double_thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_INHIBIT_THRESHOLD: inhibit_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_BUTTON_BOOST:      boost_ff       <= csr_wdata[LEVEL_W-1:0];
            CSR_POST_FIRE_LEVEL:   post_ff        <= csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Channel outputs.
   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.fire_once     = rsp_flags_ff.fire_once;
   assign rsp_ch.fire_twice    = rsp_flags_ff.fire_twice;
   assign rsp_ch.cancel_queued = rsp_flags_ff.cancel_queued;
   assign rsp_ch.potential_out = POT_OUT_W'(rsp_pot_ff);

   // A second pulse never fires without the first.
   a_twice_implies_once: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (!rsp_ch.fire_twice || rsp_ch.fire_once))
      else $error("fire_twice without fire_once");

   // Inhibition and firing exclude each other, and inhibition clears the potential.
   a_cancel_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.cancel_queued) |-> (!rsp_ch.fire_once &&
                                                  rsp_ch.potential_out == '0))
      else $error("cancel_queued with firing or nonzero potential");

   // The running power of the decay factor never exceeds one point zero.
   a_power_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (r_ff <= ONE_Q16))
      else $error("decay power above one");

   // A result word is only loaded from the final step of the sequence.
   a_result_from_decide: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_DECIDE))
      else $error("result word loaded outside the decide step");
endmodule

// File: sim/neuron_response_checker.sv
// Checker that predicts and compares every result word of the neuron unit.
module neuron_response_checker (
   input  logic                           clock,
   input  logic                           reset,
   lif_req_if                             req_ch,
   lif_rsp_if                             rsp_ch,
   input  logic                           csr_we,
   input  logic [lif_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lif_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             outstanding
);
   import lif_pkg::*;

   localparam int     TIME_BITS = TIME_BITS_DEF;
   localparam int     FRAC_BITS = FRAC_BITS_DEF;
   localparam int     POT_W     = INT_BITS + FRAC_BITS;
   localparam longint POT_MAX   = (longint'(1) <<< (POT_W - 1)) - 1;
   localparam longint POT_MIN   = -(longint'(1) <<< (POT_W - 1));
   localparam int     REPORT_LIMIT = 10;

   typedef struct {
      logic [ELAPSED_W-1:0]      elapsed_ms;
      logic signed [DELTA_W-1:0] dendrite_delta;
      logic                      button_pressed;
      logic                      spont_mode;
      logic signed [DELTA_W-1:0] spont_delta;
      logic                      queue_pending;
   } update_word_type;

   typedef struct {
      spike_flags_type              flags;
      logic signed [POT_OUT_W-1:0]  potential;
   } response_word_type;

   // Shadow copy of the configuration registers and the membrane potential.
   logic [Q16_W-1:0]          decay_per_ms;
   logic signed [THR_W-1:0]   fire_threshold;
   logic signed [THR_W-1:0]   double_threshold;
   logic signed [THR_W-1:0]   inhibit_threshold;
   logic signed [LEVEL_W-1:0] button_boost;
   logic signed [LEVEL_W-1:0] post_fire_level;
   logic signed [POT_W-1:0]   membrane;

   response_word_type expected_responses[$];
   int                response_index;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      response_index = 0;
   end

   function automatic longint saturate_potential(input longint value);
      if (value > POT_MAX) return POT_MAX;
      if (value < POT_MIN) return POT_MIN;
      return value;
   endfunction

   // Per-millisecond factor raised to the elapsed time, LSB first, truncating each product.
   function automatic longint decay_factor(input logic [Q16_W-1:0] per_ms,
                                           input logic [ELAPSED_W-1:0] ms);
      longint acc;
      longint square;
      acc    = longint'(ONE_Q16);
      square = longint'(per_ms);
      for (int i = 0; i < TIME_BITS; i++) begin
         if (ms[i]) acc = (acc * square) >>> Q16_W;
         square = (square * square) >>> Q16_W;
      end
      return acc;
   endfunction

   function automatic response_word_type integrate_update(input update_word_type w);
      longint            p;
      longint            mag;
      longint            scale;
      response_word_type r;
      scale = longint'(1) <<< FRAC_BITS;
      p     = longint'(membrane);
      mag   = (p < 0) ? -p : p;
      mag   = (mag * decay_factor(decay_per_ms, w.elapsed_ms)) >>> Q16_W;
      p     = (p < 0) ? -mag : mag;
      p     = saturate_potential(p + longint'(w.dendrite_delta) * scale);
      if (w.button_pressed) p = saturate_potential(p + longint'(button_boost) * scale);
      if (w.spont_mode) p = saturate_potential(p + longint'(w.spont_delta) * scale);
      r.flags = '0;
      if (p > longint'(double_threshold) * scale) begin
         r.flags.fire_once  = 1'b1;
         r.flags.fire_twice = 1'b1;
         p = saturate_potential(longint'(post_fire_level) * scale);
      end else if (p > longint'(fire_threshold) * scale) begin
         r.flags.fire_once = 1'b1;
         p = saturate_potential(longint'(post_fire_level) * scale);
      end else if (p < longint'(inhibit_threshold) * scale && w.queue_pending) begin
         r.flags.cancel_queued = 1'b1;
         p = 0;
      end
      membrane    = p[POT_W-1:0];
      r.potential = p[POT_OUT_W-1:0];
      return r;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic take_update();
      update_word_type w;
      w.elapsed_ms     = req_ch.elapsed_ms;
      w.dendrite_delta = req_ch.dendrite_delta;
      w.button_pressed = req_ch.button_pressed;
      w.spont_mode     = req_ch.spont_mode;
      w.spont_delta    = req_ch.spont_delta;
      w.queue_pending  = req_ch.queue_pending;
      expected_responses.push_back(integrate_update(w));
   endtask

   task automatic take_response();
      response_word_type got;
      response_word_type want;
      got.flags.fire_once     = rsp_ch.fire_once;
      got.flags.fire_twice    = rsp_ch.fire_twice;
      got.flags.cancel_queued = rsp_ch.cancel_queued;
      got.potential           = rsp_ch.potential_out;
      if (expected_responses.size() == 0) begin
         note_mismatch($sformatf("result word %0d arrived with no update pending",
                                 response_index));
      end else begin
         want = expected_responses.pop_front();
         if (got.flags !== want.flags || got.potential !== want.potential)
            note_mismatch($sformatf({"result word %0d: expected once=%0b twice=%0b ",
                                     "cancel=%0b pot=%0d, got once=%0b twice=%0b ",
                                     "cancel=%0b pot=%0d"},
               response_index, want.flags.fire_once, want.flags.fire_twice,
               want.flags.cancel_queued, want.potential, got.flags.fire_once,
               got.flags.fire_twice, got.flags.cancel_queued, got.potential));
      end
      response_index++;
   endtask

   task automatic take_csr_write();
      case (csr_index)
         CSR_DECAY_PER_MS:      decay_per_ms      = csr_wdata[Q16_W-1:0];
         CSR_FIRE_THRESHOLD:    fire_threshold    = csr_wdata[THR_W-1:0];
         CSR_DOUBLE_THRESHOLD:  double_threshold  = csr_wdata[THR_W-1:0];
         CSR_INHIBIT_THRESHOLD: inhibit_threshold = csr_wdata[THR_W-1:0];
         CSR_BUTTON_BOOST:      button_boost      = csr_wdata[LEVEL_W-1:0];
         CSR_POST_FIRE_LEVEL:   post_fire_level   = csr_wdata[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decay_per_ms      = RST_DECAY_PER_MS;
         fire_threshold    = RST_FIRE_THRESHOLD;
         double_threshold  = RST_DOUBLE_THRESHOLD;
         inhibit_threshold = RST_INHIBIT_THRESHOLD;
         button_boost      = RST_BUTTON_BOOST;
         post_fire_level   = RST_POST_FIRE_LEVEL;
         membrane          = '0;
         expected_responses.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) take_response();
         if (csr_we) take_csr_write();
         if (req_ch.valid && req_ch.ready) take_update();
      end
      outstanding = expected_responses.size();
   end

endmodule

// File: sim/leaky_integrate_fire_neuron_unit_test.sv
// Stimulus, handshake pacing and pass/fail verdict for the neuron unit.
module leaky_integrate_fire_neuron_unit_test;
   import lif_pkg::*;

   // A long quiet stretch on both channels only happens during the deliberate
   // receiver hold-off.
   localparam int LONG_HOLD_CYCLES = 500;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int END_CYCLES       = 2 * TIME_BITS_DEF + 20;
   localparam int RANDOM_PHASES    = 7;
   localparam int PHASE_WORDS      = 200;
   localparam int RX_STYLE_CYCLES  = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_POST_FIRE_LEVEL + 1'b1;

   typedef struct {
      logic [ELAPSED_W-1:0]      elapsed_ms;
      logic signed [DELTA_W-1:0] dendrite_delta;
      logic                      button_pressed;
      logic                      spont_mode;
      logic signed [DELTA_W-1:0] spont_delta;
      logic                      queue_pending;
   } neuron_update_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int quiet_cycles = 0;

   // Sender pacing state: words go out in bursts separated by random gaps, except in the gap-free phase.
   int burst_left = 1;
   bit offering = 1'b0;
   bit gap_free_phase = 1'b0;

   // Raised by the stimulus to make the receiver hold off for a long stretch.
   bit long_hold_request = 1'b0;

   lif_req_if req_ch ();
   lif_rsp_if rsp_ch ();

   leaky_integrate_fire_neuron_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   neuron_response_checker u_response_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #2 clock = ~clock;

   // Any accepted word on either channel counts as progress. If the unit goes
   // silent for far longer than the slowest legal stall, the run is abandoned.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: the stall style changes in turn from always ready through random
   // and periodic stalls. A long hold-off is counted here.
   initial begin
      int rx_cycle;
      rx_cycle = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            case ((rx_cycle / RX_STYLE_CYCLES) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ch.ready <= ((rx_cycle % 9) < 4);
            endcase
         end
      end
   end

   function automatic neuron_update_type make_update(input int ms, input int dend,
                                                     input bit press, input bit spont,
                                                     input int sdelta, input bit queued);
      neuron_update_type u;
      u.elapsed_ms     = ms[ELAPSED_W-1:0];
      u.dendrite_delta = dend[DELTA_W-1:0];
      u.button_pressed = press;
      u.spont_mode     = spont;
      u.spont_delta    = sdelta[DELTA_W-1:0];
      u.queue_pending  = queued;
      return u;
   endfunction

   // Elapsed time favors short steps so the potential builds up and fires,
   // with zero, the maximum, single bits and full-range values mixed in.
   function automatic neuron_update_type random_update();
      neuron_update_type u;
      case ($urandom_range(0, 9))
         0:       u.elapsed_ms = '0;
         1:       u.elapsed_ms = '1;
         2, 3:    u.elapsed_ms = ELAPSED_W'(1) << $urandom_range(0, ELAPSED_W - 1);
         4, 5, 6: u.elapsed_ms = ELAPSED_W'($urandom_range(1, 15));
         default: u.elapsed_ms = ELAPSED_W'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0)
         u.dendrite_delta = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      else
         u.dendrite_delta = DELTA_W'($urandom);
      if ($urandom_range(0, 7) == 0)
         u.spont_delta = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      else
         u.spont_delta = DELTA_W'($urandom);
      u.button_pressed = 1'($urandom);
      u.spont_mode     = 1'($urandom);
      u.queue_pending  = 1'($urandom);
      return u;
   endfunction

   // Offer one update word and hold it until the unit takes it, then decide
   // whether the burst continues or the sender pauses for a while.
   task automatic offer_update(input neuron_update_type u);
      int gap;
      req_ch.valid          <= 1'b1;
      req_ch.elapsed_ms     <= u.elapsed_ms;
      req_ch.dendrite_delta <= u.dendrite_delta;
      req_ch.button_pressed <= u.button_pressed;
      req_ch.spont_mode     <= u.spont_mode;
      req_ch.spont_delta    <= u.spont_delta;
      req_ch.queue_pending  <= u.queue_pending;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && !gap_free_phase) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Stop offering and wait until every update word has been answered, so
   // that the configuration registers can be rewritten safely.
   task automatic drain_unit();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Bits above the register width carry random junk; the unit must ignore them.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value, input int width);
      logic [31:0] data;
      logic [31:0] mask;
      mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
      data = ($urandom & ~mask) | (value & mask);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(negedge clock);
   endtask

   task automatic program_settings(input int decay, input int fire, input int dbl,
                                   input int inh, input int boost, input int post);
      write_csr(CSR_DECAY_PER_MS, decay, Q16_W);
      write_csr(CSR_FIRE_THRESHOLD, fire, THR_W);
      write_csr(CSR_DOUBLE_THRESHOLD, dbl, THR_W);
      write_csr(CSR_INHIBIT_THRESHOLD, inh, THR_W);
      write_csr(CSR_BUTTON_BOOST, boost, LEVEL_W);
      write_csr(CSR_POST_FIRE_LEVEL, post, LEVEL_W);
      // A write to an index past the last register must change nothing.
      write_csr(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 1)), $urandom, CSR_DATA_W);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Half of the random settings keep the thresholds in the usual order near
   // zero so the neuron fires and inhibits often; the rest use the full range.
   task automatic program_random_settings();
      int decay;
      int fire;
      int dbl;
      int inh;
      case ($urandom_range(0, 5))
         0:       decay = 0;
         1:       decay = 65535;
         2:       decay = int'($urandom_range(0, 65535));
         default: decay = int'($urandom_range(60000, 65535));
      endcase
      if ($urandom_range(0, 1)) begin
         fire = int'($urandom_range(0, 120));
         dbl  = fire + int'($urandom_range(0, 120));
         inh  = -int'($urandom_range(0, 120));
      end else begin
         fire = int'($urandom_range(0, 1023)) - 512;
         dbl  = int'($urandom_range(0, 1023)) - 512;
         inh  = int'($urandom_range(0, 1023)) - 512;
      end
      program_settings(decay, fire, dbl, inh, int'($urandom_range(0, 255)) - 128,
                       int'($urandom_range(0, 255)) - 128);
   endtask

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.elapsed_ms     = '0;
      req_ch.dendrite_delta = '0;
      req_ch.button_pressed = 1'b0;
      req_ch.spont_mode     = 1'b0;
      req_ch.spont_delta    = '0;
      req_ch.queue_pending  = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings, written explicitly. The directed words walk through
      // a double fire, plain integration, a full-length decay, cancellation
      // with and without a queued pulse, the button and spontaneous inputs,
      // and the exact threshold values where strict comparison must not fire.
      program_settings(RST_DECAY_PER_MS, RST_FIRE_THRESHOLD, RST_DOUBLE_THRESHOLD,
                       RST_INHIBIT_THRESHOLD, RST_BUTTON_BOOST, RST_POST_FIRE_LEVEL);
      offer_update(make_update(0, 127, 0, 0, 0, 0));
      offer_update(make_update(0, 20, 0, 0, 0, 0));
      offer_update(make_update(1023, 0, 0, 0, 0, 0));
      offer_update(make_update(1, -128, 0, 0, 0, 1));
      offer_update(make_update(0, -128, 0, 0, 0, 0));
      offer_update(make_update(5, 0, 1, 0, 0, 0));
      offer_update(make_update(3, 0, 0, 1, 127, 0));
      offer_update(make_update(2, 0, 0, 1, -128, 1));
      offer_update(make_update(0, 127, 0, 0, 127, 0));
      offer_update(make_update(0, 127, 1, 1, 127, 0));
      offer_update(make_update(0, 25, 0, 0, 0, 0));
      offer_update(make_update(0, 25, 0, 0, 0, 0));
      offer_update(make_update(0, -25, 0, 0, 0, 1));
      offer_update(make_update(0, -1, 0, 0, 0, 1));
      offer_update(make_update(512, 100, 0, 0, 0, 0));
      drain_unit();

      // Extreme settings: the potential is driven into negative saturation,
      // where the lowest inhibit threshold can never cancel, and then into
      // positive saturation, which fires twice and reloads the top level.
      program_settings(65535, 511, 511, -512, 127, 127);
      repeat (5) offer_update(make_update(0, -128, 0, 0, 0, 0));
      offer_update(make_update(0, -128, 0, 0, 0, 1));
      offer_update(make_update(1023, 0, 0, 0, 0, 1));
      repeat (3) offer_update(make_update(0, 127, 1, 1, 127, 0));
      drain_unit();

      // Opposite extremes with the double threshold at or below the fire
      // threshold, so every potential above it fires twice, and a zero factor.
      program_settings(0, -512, -512, 511, -128, -128);
      offer_update(make_update(700, 0, 0, 0, 0, 0));
      offer_update(make_update(0, -128, 1, 0, 0, 1));
      drain_unit();

      // Random phases, each under its own settings. One phase runs without
      // sender gaps, and one triggers the long receiver hold-off mid-stream
      // while the sender keeps offering, which backs up the whole unit.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            program_settings(RST_DECAY_PER_MS, RST_FIRE_THRESHOLD, RST_DOUBLE_THRESHOLD,
                             RST_INHIBIT_THRESHOLD, RST_BUTTON_BOOST, RST_POST_FIRE_LEVEL);
         else
            program_random_settings();
         gap_free_phase = (phase == 4);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase == 2 && n == 60) long_hold_request = 1'b1;
            offer_update(random_update());
         end
         drain_unit();
      end
      gap_free_phase = 1'b0;

      repeat (END_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
